// ===== rtl/sog_pkg.sv =====
package sog_pkg;

    localparam int NUM_DIMS       = 4;
    localparam int RANK_DEF       = 4;
    localparam int INDEX_BITS_DEF = 32;

    localparam int FLAT_W  = 32;
    localparam int EXT_W   = 16;
    localparam int STEP_W  = 32;
    localparam int PROD_W  = EXT_W + STEP_W;
    localparam int OFS_W   = 50;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [EXT_W-1:0]  EXT_RST       = EXT_W'(1);
    localparam logic [STEP_W-1:0] STEP_RST      = '0;
    localparam logic [STEP_W-1:0] STEP_INNER_RST = STEP_W'(1);

    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_1 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_3 = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_STEP_0   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_STEP_1   = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_STEP_2   = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_STEP_3   = CFG_IDX_W'(7);

endpackage

// ===== rtl/strided_offset_generator_top.sv =====
// strided offset generator: flat row-major element number in, element offset out
//
// command channel: a transaction is taken at a rising edge with start high and
// busy low. busy stays low, so a new flat_number may be given every cycle.
// result channel: done is high for exactly one cycle with element_offset valid;
// the receiver cannot stall, so no backpressure exists anywhere in the pipe.
// config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. index 0..3 are extent_0..extent_3, 4..7 are step_0..step_3,
// other indexes are dropped. write only while no transaction is in flight.
// each dimension is one restoring divider of min(INDEX_BITS,32) stages, one
// bit per stage, then a 16x32 multiply stage and an accumulate stage.
// throughput: one transaction per cycle.
// reset: pipe is emptied, extents go to 1, strides to 0 except step_3 to 1.
module strided_offset_generator_top #(
    parameter int RANK       = sog_pkg::RANK_DEF,
    parameter int INDEX_BITS = sog_pkg::INDEX_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [sog_pkg::FLAT_W-1:0]       flat_number,
    output logic                             done,
    output logic [sog_pkg::OFS_W-1:0]        element_offset,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sog_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sog_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int IW   = (INDEX_BITS < sog_pkg::FLAT_W) ? INDEX_BITS : sog_pkg::FLAT_W;
    localparam int NDIM = (RANK < sog_pkg::NUM_DIMS) ? RANK : sog_pkg::NUM_DIMS;
    localparam int SPD  = IW + 2;
    localparam int LAT  = NDIM * SPD;

    localparam int EXT_W  = sog_pkg::EXT_W;
    localparam int STEP_W = sog_pkg::STEP_W;
    localparam int PROD_W = sog_pkg::PROD_W;
    localparam int OFS_W  = sog_pkg::OFS_W;

    logic [EXT_W-1:0]  extent_reg [sog_pkg::NUM_DIMS];
    logic [STEP_W-1:0] step_reg   [sog_pkg::NUM_DIMS];

    logic              vld_reg  [LAT];
    logic [IW-1:0]     num_reg  [LAT];
    logic [EXT_W-1:0]  rem_reg  [LAT];
    logic [OFS_W-1:0]  acc_reg  [LAT];
    logic [PROD_W-1:0] prod_reg [NDIM];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sog_pkg::NUM_DIMS; i++)
            begin
                extent_reg[i] <= sog_pkg::EXT_RST;
                step_reg[i]   <= sog_pkg::STEP_RST;
            end
            step_reg[sog_pkg::NUM_DIMS-1] <= sog_pkg::STEP_INNER_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sog_pkg::REG_EXTENT_0: extent_reg[0] <= cfg_data[EXT_W-1:0];
                sog_pkg::REG_EXTENT_1: extent_reg[1] <= cfg_data[EXT_W-1:0];
                sog_pkg::REG_EXTENT_2: extent_reg[2] <= cfg_data[EXT_W-1:0];
                sog_pkg::REG_EXTENT_3: extent_reg[3] <= cfg_data[EXT_W-1:0];
                sog_pkg::REG_STEP_0:   step_reg[0]   <= cfg_data[STEP_W-1:0];
                sog_pkg::REG_STEP_1:   step_reg[1]   <= cfg_data[STEP_W-1:0];
                sog_pkg::REG_STEP_2:   step_reg[2]   <= cfg_data[STEP_W-1:0];
                sog_pkg::REG_STEP_3:   step_reg[3]   <= cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // k counts dimensions from the innermost outward
    for (genvar k = 0; k < NDIM; k++)
    begin : g_dim
        localparam int D = sog_pkg::NUM_DIMS - 1 - k;

        logic [EXT_W-1:0]  ext;
        logic [STEP_W-1:0] step;

        assign ext  = extent_reg[D];
        assign step = step_reg[D];

        for (genvar s = 0; s < SPD; s++)
        begin : g_stage
            localparam int G = k * SPD + s;

            logic              vld_in;
            logic [IW-1:0]     num_in;
            logic [EXT_W-1:0]  rem_in;
            logic [OFS_W-1:0]  acc_in;
            logic [IW-1:0]     num_next;
            logic [EXT_W-1:0]  rem_next;
            logic [OFS_W-1:0]  acc_next;

            if (G == 0)
            begin : g_head
                assign vld_in = start && !busy;
                assign num_in = flat_number[IW-1:0];
                assign rem_in = '0;
                assign acc_in = '0;
            end
            else
            begin : g_link
                assign vld_in = vld_reg[G-1];
                assign num_in = num_reg[G-1];
                assign rem_in = rem_reg[G-1];
                assign acc_in = acc_reg[G-1];
            end

            if (s < IW)
            begin : g_div
                logic [EXT_W:0] trial;
                logic [EXT_W:0] diff;
                logic           ge;

                // one quotient bit per stage
                always_comb
                begin
                    trial    = {rem_in, num_in[IW-1]};
                    diff     = trial - {1'b0, ext};
                    ge       = (trial >= {1'b0, ext});
                    rem_next = ge ? diff[EXT_W-1:0] : trial[EXT_W-1:0];
                    num_next = {num_in[IW-2:0], ge};
                    acc_next = acc_in;
                end
            end
            else if (s == IW)
            begin : g_mul
                logic             ext_zero;
                logic [EXT_W-1:0] coord;

                // zero extent: coordinate and quotient are zero; the remainder is always cleared
                always_comb
                begin
                    ext_zero = (ext == '0);
                    coord    = ext_zero ? '0 : rem_in;
                    num_next = ext_zero ? '0 : num_in;
                    rem_next = '0;
                    acc_next = acc_in;
                end

                always_ff @(posedge clk)
                begin
                    prod_reg[k] <= PROD_W'(coord) * PROD_W'(step);
                end
            end
            else
            begin : g_acc
                always_comb
                begin
                    num_next = num_in;
                    rem_next = rem_in;
                    acc_next = acc_in + OFS_W'(prod_reg[k]);
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[G] <= 1'b0;
                end
                else
                begin
                    vld_reg[G] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                num_reg[G] <= num_next;
                rem_reg[G] <= rem_next;
                acc_reg[G] <= acc_next;
            end
        end
    end

    assign done           = vld_reg[LAT-1];
    assign element_offset = acc_reg[LAT-1];

endmodule
